// File: rtl/edge_gap_closure_3x3_unit_defines.svh
// Assertion macros for the edge gap closure unit checker.
// Expects i_clk and i_rst_n in the scope that uses them.
`ifndef EDGE_GAP_CLOSURE_3X3_UNIT_DEFINES_SVH
`define EDGE_GAP_CLOSURE_3X3_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EGC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define EGC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, active through reset
`define EGC_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/egc_pkg.sv
// Shared types and constants for the edge gap closure unit.
// No dependencies.
`default_nettype none

package egc_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WCNT_W     = COL_W + 1;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int HCNT_W     = ROW_W + 1;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int PIX_W      = 8;
    localparam int COLSUM_W   = 10;
    localparam int SUM_W      = 11;
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int RECIP_SH   = 16;
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;   // ceil(2^16 / 9)
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_W      = CNT_W + 1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    typedef struct packed {
        t_pix up;
        t_pix mid;
    } t_ls_word;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        t_ls_word         data;
    } t_ls_wr;

    typedef struct packed {
        t_pix pixel;
        logic frame_end;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/egc_in_if.sv
// Input pixel channel: valid/ready with pixel and frame start.
// Depends on egc_pkg.
`default_nettype none

interface egc_in_if import egc_pkg::*; ();
    logic valid;
    logic ready;
    t_pix pixel_in;
    logic frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

`default_nettype wire

// File: rtl/egc_out_if.sv
// Output pixel channel: valid/ready with closed pixel and frame end.
// Depends on egc_pkg.
`default_nettype none

interface egc_out_if import egc_pkg::*; ();
    logic valid;
    logic ready;
    t_pix pixel_out;
    logic frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/egc_line_store.sv
// Paired line store (upper and middle rows) with registered read and write bypass.
// Unwritten entries read as zero through a fill count. Depends on egc_pkg.
`default_nettype none

module egc_line_store import egc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [COL_W-1:0] i_rd_addr,
    input  t_ls_wr           i_wr,
    output t_ls_word         o_rd_data
);

    t_ls_word          r_mem [MAX_WIDTH];
    t_ls_word          r_rd_mem;
    t_ls_word          r_fwd_data;
    logic              r_fwd;
    logic              r_rd_zero;
    logic [WCNT_W-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_mem   <= r_mem[i_rd_addr];
        r_fwd_data <= i_wr.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_fwd     <= 1'b0;
            r_rd_zero <= 1'b1;
        end else begin
            r_fwd     <= i_wr.en && (i_wr.addr == i_rd_addr);
            r_rd_zero <= {1'b0, i_rd_addr} >= r_fill;
            if (i_wr.en && ({1'b0, i_wr.addr} == r_fill)) begin
                r_fill <= r_fill + WCNT_W'(1);
            end
        end
    end

    assign o_rd_data = r_fwd     ? r_fwd_data :
                       r_rd_zero ? t_ls_word'('0) : r_rd_mem;

endmodule

`default_nettype wire

// File: rtl/egc_col_cell.sv
// One column cell of the 3x3 window; shifts its column to the next cell.
// Provides nonzero flags and column sum. Depends on egc_pkg.
`default_nettype none

module egc_col_cell import egc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  t_col                i_col,
    output t_col                o_col,
    output logic [2:0]          o_nz,
    output logic [COLSUM_W-1:0] o_sum
);

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
    assign o_nz  = {r_col.top != '0, r_col.mid != '0, r_col.bot != '0};
    assign o_sum = COLSUM_W'(r_col.top) + COLSUM_W'(r_col.mid) + COLSUM_W'(r_col.bot);

endmodule

`default_nettype wire

// File: rtl/egc_out_fifo.sv
// Output queue decoupling the pixel pipeline from the result channel.
// Depends on egc_pkg and egc_out_if.
`default_nettype none

module egc_out_fifo import egc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_res             i_data,
    output logic [CNT_W-1:0] o_count,
    egc_out_if.source        o_q
);

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               pop;

    assign pop = o_q.valid && o_q.ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_count       = r_count;
    assign o_q.valid     = r_count != '0;
    assign o_q.pixel_out = r_mem[r_rd_ptr].pixel;
    assign o_q.frame_end = r_mem[r_rd_ptr].frame_end;

endmodule

`default_nettype wire

// File: rtl/edge_gap_closure_3x3_unit.sv
// Top level of the edge gap closure unit: counters, line store, window cells, output queue.
// Depends on egc_pkg, egc_in_if, egc_out_if, egc_line_store, egc_col_cell, egc_out_fifo.
//
//   channel   dir   handshake      payload
//   i_pix     in    valid/ready    pixel_in[7:0], frame_start
//   o_pix     out   valid/ready    pixel_out[7:0], frame_end
//   i_cfg_*   in    write enable   index 0 frame_width, 1 frame_height, 13-bit data
//
// One pixel per clock while i_pix.ready is high; an accepted transaction passes the
// line store read, window shift, sum/flags register, reciprocal multiply, output queue.
// Reset: no clearing pass; a fill count makes unwritten line store entries read as zero.
// Stalls: an 8-entry output queue; i_pix.ready drops when queue plus pipeline hold 8.
`default_nettype none

module edge_gap_closure_3x3_unit import egc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    egc_in_if.sink               i_pix,
    egc_out_if.source            o_pix,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]  r_frame_width;
    logic [CFG_W-1:0]  r_frame_height;
    logic [WCNT_W-1:0] w_eff;
    logic [HCNT_W-1:0] h_eff;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [WCNT_W-1:0] col_inc;
    logic [HCNT_W-1:0] row_inc;
    logic              accept;
    logic              cur_int;
    logic              cur_fend;

    logic              r_s1_valid;
    t_pix              r_s1_pix;
    logic [COL_W-1:0]  r_s1_idx;
    logic              r_s1_int;
    logic              r_s1_fend;

    logic              r_s2_valid;
    logic              r_s2_int;
    logic              r_s2_fend;

    logic              r_s3_valid;
    logic              r_s3_int;
    logic              r_s3_fend;
    logic              r_s3_hit;
    t_pix              r_s3_center;
    logic [SUM_W-1:0]  r_s3_sum;

    t_ls_word          rd_data;
    t_ls_wr            ls_wr;
    t_col              cell_in;
    t_col              col0;
    t_col              col1;
    t_col              col2;
    logic [2:0]        nz0;
    logic [2:0]        nz1;
    logic [2:0]        nz2;
    logic [COLSUM_W-1:0] sum0;
    logic [COLSUM_W-1:0] sum1;
    logic [COLSUM_W-1:0] sum2;
    logic              n0, n1, n2, n3, n5, n6, n7, n8;
    logic              hit;
    logic [SUM_W-1:0]  win_sum;
    logic [PROD_W-1:0] prod;
    t_pix              quot;
    t_res              res;
    logic [CNT_W-1:0]  fifo_count;
    logic [OCC_W-1:0]  occ;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(640);
            r_frame_height <= CFG_W'(480);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width < CFG_W'(3)) begin
            w_eff = WCNT_W'(3);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WCNT_W'(MAX_WIDTH);
        end else begin
            w_eff = WCNT_W'(r_frame_width);
        end
        if (r_frame_height < CFG_W'(3)) begin
            h_eff = HCNT_W'(3);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h_eff = HCNT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HCNT_W'(r_frame_height);
        end
    end

    // position counters
    assign accept  = i_pix.valid && i_pix.ready;
    assign cur_col = i_pix.frame_start ? '0 : r_col;
    assign cur_row = i_pix.frame_start ? '0 : r_row;
    assign col_inc = {1'b0, cur_col} + WCNT_W'(1);
    assign row_inc = {1'b0, cur_row} + HCNT_W'(1);
    assign cur_int  = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
    assign cur_fend = ({1'b0, cur_row} == h_eff - HCNT_W'(1)) &&
                      ({1'b0, cur_col} == w_eff - WCNT_W'(1));

    always_comb begin
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = ({1'b0, cur_row} >= h_eff) ? '0 : cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1: line store read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix  <= i_pix.pixel_in;
        r_s1_idx  <= cur_col;
        r_s1_int  <= cur_int;
        r_s1_fend <= cur_fend;
    end

    assign ls_wr.en        = r_s1_valid;
    assign ls_wr.addr      = r_s1_idx;
    assign ls_wr.data.up   = rd_data.mid;
    assign ls_wr.data.mid  = r_s1_pix;

    egc_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (cur_col),
        .i_wr      (ls_wr),
        .o_rd_data (rd_data)
    );

    assign cell_in.top = rd_data.up;
    assign cell_in.mid = rd_data.mid;
    assign cell_in.bot = r_s1_pix;

    // window cells: col2 newest, col0 oldest
    egc_col_cell u_cell2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_shift (r_s1_valid),
        .i_col (cell_in), .o_col (col2), .o_nz (nz2), .o_sum (sum2)
    );

    egc_col_cell u_cell1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_shift (r_s1_valid),
        .i_col (col2), .o_col (col1), .o_nz (nz1), .o_sum (sum1)
    );

    egc_col_cell u_cell0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_shift (r_s1_valid),
        .i_col (col1), .o_col (col0), .o_nz (nz0), .o_sum (sum0)
    );

    // stage 2: window holds the new neighborhood
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_int  <= r_s1_int;
        r_s2_fend <= r_s1_fend;
    end

    assign n0 = nz0[2];
    assign n1 = nz1[2];
    assign n2 = nz2[2];
    assign n3 = nz0[1];
    assign n5 = nz2[1];
    assign n6 = nz0[0];
    assign n7 = nz1[0];
    assign n8 = nz2[0];

    assign hit = (n0 && (n5 || n7 || n8)) || (n1 && (n6 || n7 || n8)) ||
                 (n2 && (n3 || n6 || n7)) || (n3 && (n5 || n8)) ||
                 (n5 && (n0 || n3 || n6)) || (n6 && (n1 || n2 || n5)) ||
                 (n7 && (n3 || n1 || n2)) || (n8 && (n0 || n1 || n3));

    // center is zero whenever the sum is used
    assign win_sum = SUM_W'(sum0) + SUM_W'(sum1) + SUM_W'(sum2);

    // stage 3: flags and sum registered, divide by 9 via reciprocal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_int    <= r_s2_int;
        r_s3_fend   <= r_s2_fend;
        r_s3_hit    <= hit;
        r_s3_center <= col1.mid;
        r_s3_sum    <= win_sum;
    end

    assign prod = PROD_W'(r_s3_sum) * PROD_W'(RECIP_9);
    assign quot = prod[RECIP_SH +: PIX_W];

    always_comb begin
        if (!r_s3_int) begin
            res.pixel = '0;
        end else if (r_s3_center != '0) begin
            res.pixel = r_s3_center;
        end else if (r_s3_hit) begin
            res.pixel = quot;
        end else begin
            res.pixel = '0;
        end
        res.frame_end = r_s3_fend;
    end

    egc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s3_valid),
        .i_data  (res),
        .o_count (fifo_count),
        .o_q     (o_pix)
    );

    assign occ = OCC_W'(fifo_count) + OCC_W'(r_s1_valid) + OCC_W'(r_s2_valid) +
                 OCC_W'(r_s3_valid);
    assign i_pix.ready = occ < OCC_W'(FIFO_DEPTH);

endmodule

`default_nettype wire

// File: rtl/egc_checker.sv
// Port-level assertions for edge_gap_closure_3x3_unit, attached by bind.
// Depends on edge_gap_closure_3x3_unit_defines.svh.
`default_nettype none
`include "edge_gap_closure_3x3_unit_defines.svh"

module egc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_pixel,
    input logic       i_out_frame_end
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // stalled result transaction holds
    `EGC_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_pixel) && $stable(i_out_frame_end), "stalled output changed")

    // after reset: queue empty, input ready
    `EGC_ASSERT_RST(a_rst_state, !i_rst_n, !i_out_valid && i_in_ready, "bad state after reset")

    // no result without an accepted input transaction within pipeline depth
    `EGC_ASSERT_NXT(a_no_invent, !in_acc ##1 !in_acc ##1 !in_acc ##1 (!i_out_valid && !in_acc), !i_out_valid, "result without input")

    // an idle queue never blocks input
    `EGC_ASSERT_IMP(a_ready_idle, !i_out_valid && !$past(in_acc) && !$past(in_acc, 2) && !$past(in_acc, 3), i_in_ready, "input blocked while idle")

endmodule

bind edge_gap_closure_3x3_unit egc_checker u_egc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_out_valid     (o_pix.valid),
    .i_out_ready     (o_pix.ready),
    .i_out_pixel     (o_pix.pixel_out),
    .i_out_frame_end (o_pix.frame_end)
);

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for edge_gap_closure_3x3_unit: directed, clamped and random frames.
// Depends on egc_pkg, egc_in_if, egc_out_if and the unit; results are checked against
// a cycle-free predictor of the closing rules kept in this module, or typed directed results.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import egc_pkg::*;

    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned RANDOM_PIXELS = 950;
    localparam int unsigned LONG_HOLD     = 150;

    typedef struct {
        bit          reconf;
        logic [12:0] set_w;
        logic [12:0] set_h;
        t_pix        pix;
        bit          fs;
        bit          typed;
        t_pix        want_pix;
        bit          want_end;
    } t_dir_step;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    egc_in_if  pix_in_if ();
    egc_out_if pix_out_if ();

    edge_gap_closure_3x3_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_in_if),
        .o_pix       (pix_out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [12:0]      frame_w_reg = 13'd640;
    logic [12:0]      frame_h_reg = 13'd480;
    bit [PIX_W-1:0]   upper_row  [MAX_WIDTH];
    bit [PIX_W-1:0]   middle_row [MAX_WIDTH];
    bit [PIX_W-1:0]   nbhd [3][3];
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;

    t_res        closed_pixels_q [$];
    int unsigned errors          = 0;
    int unsigned results_checked = 0;
    int unsigned pixels_sent     = 0;
    int unsigned gaps_closed     = 0;
    int unsigned settings_used   = 1;
    int unsigned quiet_cycles    = 0;
    bit          calm            = 1'b0;
    bit          squeeze         = 1'b0;

    t_dir_step directed_pixels [25] = '{
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b1, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd1,   1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd128, 1'b0, 1'b1, 8'd0,   1'b0},
        // 3x3 frame, sizes below range, all edges
        '{1'b1, 13'd2, 13'd1, 8'd255, 1'b1, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd255, 1'b1},
        // next frame by wrap, zero center ringed by edges
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd255, 1'b0, 1'b1, 8'd226, 1'b1},
        '{1'b0, 13'd0, 13'd0, 8'd0,   1'b1, 1'b0, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd7,   1'b0, 1'b0, 8'd0,   1'b0},
        '{1'b0, 13'd0, 13'd0, 8'd200, 1'b0, 1'b0, 8'd0,   1'b0}
    };

    function automatic int unsigned clamp_dim(logic [12:0] v, int unsigned top);
        if (v < 3) return 3;
        if (v > top) return top;
        return 32'(v);
    endfunction

    function automatic t_pix close_centre();
        bit n0, n1, n2, n3, n5, n6, n7, n8, hit;
        int unsigned sum;
        if (nbhd[1][1] != 0) return nbhd[1][1];
        n0 = nbhd[0][0] != 0;
        n1 = nbhd[0][1] != 0;
        n2 = nbhd[0][2] != 0;
        n3 = nbhd[1][0] != 0;
        n5 = nbhd[1][2] != 0;
        n6 = nbhd[2][0] != 0;
        n7 = nbhd[2][1] != 0;
        n8 = nbhd[2][2] != 0;
        sum = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                sum += nbhd[r][c];
        hit = (n0 && (n5 || n7 || n8)) || (n1 && (n6 || n7 || n8)) ||
              (n2 && (n3 || n6 || n7)) || (n3 && (n5 || n8)) ||
              (n5 && (n0 || n3 || n6)) || (n6 && (n1 || n2 || n5)) ||
              (n7 && (n3 || n1 || n2)) || (n8 && (n0 || n1 || n3));
        return hit ? t_pix'(sum / 9) : t_pix'(0);
    endfunction

    function automatic t_res predict_closed_pixel(t_pix pix, bit fs);
        int unsigned w, h, slot;
        t_res res;
        w = clamp_dim(frame_w_reg, MAX_WIDTH);
        h = clamp_dim(frame_h_reg, MAX_HEIGHT);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        slot = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
        for (int r = 0; r < 3; r++) begin
            nbhd[r][0] = nbhd[r][1];
            nbhd[r][1] = nbhd[r][2];
        end
        nbhd[0][2] = upper_row[slot];
        nbhd[1][2] = middle_row[slot];
        nbhd[2][2] = pix;
        upper_row[slot]  = nbhd[1][2];
        middle_row[slot] = pix;
        res.pixel = '0;
        if (row_pos >= 2 && col_pos >= 2) begin
            res.pixel = close_centre();
            if (nbhd[1][1] == 0 && res.pixel != 0) gaps_closed++;
        end
        res.frame_end = (row_pos == h - 1 && col_pos == w - 1);
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        return res;
    endfunction

    function automatic int unsigned sender_gap();
        int unsigned r;
        if (calm || squeeze) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_pix edge_pixel(int unsigned density);
        int unsigned r;
        if ($urandom_range(0, 99) >= density) return '0;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'd255;
        if (r < 6) return t_pix'($urandom_range(1, 3));
        return t_pix'($urandom_range(1, 255));
    endfunction

    function automatic logic [12:0] pick_size(int unsigned common_hi, int unsigned rare_hi);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 8) return 13'($urandom_range(3, common_hi));
        if (r == 8) return 13'($urandom_range(0, 2));
        return 13'($urandom_range(common_hi + 1, rare_hi));
    endfunction

    function automatic int unsigned pick_density();
        case ($urandom_range(0, 3))
            0: return 8;
            1: return 25;
            2: return 50;
            default: return 85;
        endcase
    endfunction

    task automatic send_pixel(t_pix pix, bit fs, bit typed, t_res typed_res);
        t_res predicted;
        int unsigned gap;
        @(negedge i_clk);
        pix_in_if.valid       <= 1'b1;
        pix_in_if.pixel_in    <= pix;
        pix_in_if.frame_start <= fs;
        do @(posedge i_clk); while (!pix_in_if.ready);
        predicted = predict_closed_pixel(pix, fs);
        if (typed) predicted = typed_res;
        closed_pixels_q.insert(closed_pixels_q.size(), predicted);
        pixels_sent++;
        gap = sender_gap();
        if (gap != 0) begin
            @(negedge i_clk) pix_in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_frame(int unsigned len, bit first_fs, int unsigned fs_pct,
                              int unsigned density);
        bit fs;
        for (int unsigned i = 0; i < len; i++) begin
            fs = (i == 0) ? first_fs : ($urandom_range(0, 99) < fs_pct);
            send_pixel(edge_pixel(density), fs, 1'b0, '0);
        end
    endtask

    task automatic settle();
        @(negedge i_clk) pix_in_if.valid <= 1'b0;
        wait (closed_pixels_q.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_frame(logic [12:0] w, logic [12:0] h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk) frame_w_reg = w;
        @(negedge i_clk);
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk) frame_h_reg = h;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // stimulus
    initial begin
        int unsigned random_pixels, phase_no, ew, eh, frames, len;
        bit tidy;
        pix_in_if.valid       = 1'b0;
        pix_in_if.pixel_in    = '0;
        pix_in_if.frame_start = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_FRAME_WIDTH;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (directed_pixels[k]) begin
            if (directed_pixels[k].reconf) begin
                settle();
                set_frame(directed_pixels[k].set_w, directed_pixels[k].set_h);
            end
            send_pixel(directed_pixels[k].pix, directed_pixels[k].fs, directed_pixels[k].typed,
                       '{directed_pixels[k].want_pix, directed_pixels[k].want_end});
        end
        settle();

        // widest setting, clamped: head of the first row
        calm = 1'b1;
        set_frame(13'h1FFF, 13'd3);
        send_frame(120, 1'b1, 0, 10);
        settle();
        calm = 1'b0;
        set_frame(13'd3, 13'h1FFF);
        send_frame(90, 1'b1, 0, 40);
        settle();

        random_pixels = 0;
        phase_no = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            if (phase_no == 0 || $urandom_range(0, 3) != 0)
                set_frame(pick_size(12, 40), pick_size(8, 20));
            ew = clamp_dim(frame_w_reg, MAX_WIDTH);
            eh = clamp_dim(frame_h_reg, MAX_HEIGHT);
            calm = ($urandom_range(0, 4) == 0);
            squeeze = (phase_no == 2);
            frames = squeeze ? 3 : $urandom_range(1, 3);
            repeat (frames) begin
                tidy = ($urandom_range(0, 99) < 80);
                len = tidy ? ew * eh : $urandom_range(1, ew * eh);
                send_frame(len, tidy ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1)),
                           tidy ? 0 : 3, pick_density());
                random_pixels += len;
            end
            settle();
            phase_no++;
        end

        repeat (8) @(posedge i_clk);
        $display("%0d pixels in %0d frame settings, %0d results checked, %0d gaps closed",
                 pixels_sent, settings_used, results_checked, gaps_closed);
        $display("covered clamped and extreme sizes, mid-frame resizes, stalls and back-pressure");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result sink with random back-pressure
    initial begin
        bit level, held_long;
        int unsigned len, pick;
        pix_out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            pick = $urandom_range(0, 99);
            held_long = 1'b0;
            if (squeeze) begin
                level = 1'b0;
                len = LONG_HOLD;
                held_long = 1'b1;
            end else if (calm || pick < 65) begin
                level = 1'b1;
                len = calm ? 1 : $urandom_range(1, 16);
            end else if (pick < 92) begin
                level = 1'b0;
                len = $urandom_range(1, 3);
            end else begin
                level = 1'b0;
                len = $urandom_range(10, 40);
            end
            @(negedge i_clk) pix_out_if.ready <= level;
            repeat (len - 1) @(negedge i_clk);
            if (held_long) squeeze = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pix_out_if.valid && pix_out_if.ready) begin
            if (closed_pixels_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction pixel_out=%0d frame_end=%0b", $time,
                         pix_out_if.pixel_out, pix_out_if.frame_end);
            end else begin
                want = closed_pixels_q.pop_front();
                results_checked++;
                if (pix_out_if.pixel_out !== want.pixel) begin
                    errors++;
                    $display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel,
                             pix_out_if.pixel_out);
                end
                if (pix_out_if.frame_end !== want.frame_end) begin
                    errors++;
                    $display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end,
                             pix_out_if.frame_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (pix_in_if.valid && pix_in_if.ready) ||
            (pix_out_if.valid && pix_out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                     STALL_LIMIT, closed_pixels_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

`default_nettype wire
